[hdl/bwm_pkg.sv]
package bwm_pkg;

    localparam int MaxBp    = 16;
    localparam int LogDepth = 256;
    localparam int BpIdxW   = $clog2(MaxBp);
    localparam int BpCntW   = $clog2(MaxBp + 1);
    localparam int LogIdxW  = $clog2(LogDepth);
    localparam int LogCntW  = $clog2(LogDepth + 1);
    localparam int LogW     = 60;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_CLR_TBL = 3'd1;
    localparam logic [2:0] ACT_CLR_HIT = 3'd2;
    localparam logic [2:0] ACT_OBSERVE = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_value;
        logic        value_present;
        logic        enable_bit;
        logic [15:0] cpu_pc;
        logic [7:0]  log_index;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  status;
        logic [15:0] bp_id;
        logic [2:0]  rec_kind;
        logic [15:0] rec_pc;
        logic [15:0] rec_address;
        logic [7:0]  rec_value;
        logic        rec_value_present;
        logic [8:0]  log_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;
    } sts_t;

endpackage

[hdl/bwm_ram.sv]
module bwm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/bwm_ctrl.sv]
module bwm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bwm_pkg::sts_t sts,
    output bwm_pkg::cmd_t cmd,
    output logic          busy
);
    import bwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.exec = 1'b1;
                    if (sts.need_read)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_READ);
endmodule

[hdl/bwm_dp.sv]
module bwm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bwm_pkg::cmd_t      cmd,
    input  bwm_pkg::in_item_t  item,
    output bwm_pkg::sts_t      sts,
    output logic               done,
    output bwm_pkg::out_item_t res
);
    import bwm_pkg::*;

    // table rows: enabled, kind, address, value, present, id
    logic              en_reg   [MaxBp];
    logic [2:0]        kind_reg [MaxBp];
    logic [15:0]       addr_reg [MaxBp];
    logic [7:0]        val_reg  [MaxBp];
    logic              pres_reg [MaxBp];
    logic [15:0]       id_reg   [MaxBp];
    logic [BpCntW-1:0] bp_count_reg;
    logic [15:0]       next_id_reg;
    logic              pending_reg;
    logic [LogIdxW-1:0] head_reg;
    logic [LogCntW-1:0] fill_reg;
    logic              done_reg;
    out_item_t         res_reg, res_next;
    logic [LogCntW-1:0] rd_fill_reg;

    logic [7:0]        in_val;
    logic [MaxBp-1:0]  match;
    logic              any_match;
    logic [BpIdxW-1:0] win;
    logic              is_add, is_obs, is_read, read_ok, do_hit;
    logic              log_we;
    logic [LogIdxW-1:0] log_waddr, log_raddr;
    logic [LogW-1:0]   log_wdata, log_rdata;

    assign in_val  = item.value_present ? item.data_value : 8'd0;
    assign is_add  = cmd.exec && (item.action == ACT_ADD);
    assign is_obs  = cmd.exec && (item.action == ACT_OBSERVE);
    assign is_read = item.action == ACT_READ;
    assign read_ok = {{(LogCntW-8){1'b0}}, item.log_index} < fill_reg;
    assign sts.need_read = is_read && read_ok;

    always_comb
    begin
        for (int i = 0; i < MaxBp; i++)
        begin
            match[i] = (i < int'(bp_count_reg)) && en_reg[i]
                && (kind_reg[i] == item.kind) && (addr_reg[i] == item.address)
                && (!pres_reg[i] || (item.value_present && val_reg[i] == in_val));
        end
        any_match = |match;
        win = '0;
        for (int i = MaxBp - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                win = BpIdxW'(i);
            end
        end
    end

    assign do_hit    = is_obs && !pending_reg && any_match;
    assign log_we    = do_hit;
    assign log_waddr = (fill_reg < LogCntW'(LogDepth))
                       ? head_reg + fill_reg[LogIdxW-1:0] : head_reg;
    assign log_wdata = {id_reg[win], item.kind, item.cpu_pc, item.address,
                        in_val, item.value_present};
    assign log_raddr = head_reg + item.log_index[LogIdxW-1:0];

    bwm_ram #(.Width(LogW), .Depth(LogDepth)) u_log (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (is_add && bp_count_reg < BpCntW'(MaxBp))
        begin
            en_reg[bp_count_reg[BpIdxW-1:0]]   <= item.enable_bit;
            kind_reg[bp_count_reg[BpIdxW-1:0]] <= item.kind;
            addr_reg[bp_count_reg[BpIdxW-1:0]] <= item.address;
            val_reg[bp_count_reg[BpIdxW-1:0]]  <= in_val;
            pres_reg[bp_count_reg[BpIdxW-1:0]] <= item.value_present;
            id_reg[bp_count_reg[BpIdxW-1:0]]   <= next_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_count_reg <= '0;
            next_id_reg  <= '0;
            pending_reg  <= 1'b0;
            head_reg     <= '0;
            fill_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.exec && !sts.need_read) || cmd.finish;
            if (cmd.exec)
            begin
                unique case (item.action)
                    ACT_ADD:
                    begin
                        if (bp_count_reg < BpCntW'(MaxBp))
                        begin
                            bp_count_reg <= bp_count_reg + 1'b1;
                            next_id_reg  <= next_id_reg + 16'd1;
                        end
                    end
                    ACT_CLR_TBL: bp_count_reg <= '0;
                    ACT_CLR_HIT:
                    begin
                        head_reg    <= '0;
                        fill_reg    <= '0;
                        pending_reg <= 1'b0;
                    end
                    ACT_OBSERVE:
                    begin
                        if (do_hit)
                        begin
                            pending_reg <= 1'b1;
                            if (fill_reg < LogCntW'(LogDepth))
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            else
                            begin
                                head_reg <= head_reg + 1'b1;
                            end
                        end
                    end
                    ACT_RELEASE: pending_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // result assembly; log reads are completed in S_READ from registered RAM data
    always_comb
    begin
        res_next = '0;
        priority if (is_add)
        begin
            if (bp_count_reg < BpCntW'(MaxBp))
            begin
                res_next.bp_id = next_id_reg;
            end
            else
            begin
                res_next.status = ST_FULL;
            end
            res_next.log_count = 9'(fill_reg);
        end
        else if (do_hit)
        begin
            res_next.hit               = 1'b1;
            res_next.bp_id             = id_reg[win];
            res_next.rec_kind          = item.kind;
            res_next.rec_pc            = item.cpu_pc;
            res_next.rec_address       = item.address;
            res_next.rec_value         = in_val;
            res_next.rec_value_present = item.value_present;
            res_next.log_count = (fill_reg < LogCntW'(LogDepth))
                                 ? 9'(fill_reg + 1'b1) : 9'(fill_reg);
        end
        else if (is_read && !read_ok)
        begin
            res_next.status    = ST_IDX;
            res_next.log_count = 9'(fill_reg);
        end
        else if (item.action == ACT_CLR_HIT)
        begin
            res_next.log_count = '0;
        end
        else
        begin
            res_next.log_count = 9'(fill_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_reg     <= res_next;
            rd_fill_reg <= fill_reg;
        end
    end

    assign done = done_reg;

    logic read_phase_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_phase_reg <= 1'b0;
        end
        else
        begin
            read_phase_reg <= cmd.finish;
        end
    end

    // a read result carries the RAM word captured at finish
    out_item_t rd_res_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rd_res_reg <= {1'b0, ST_OK, log_rdata, 9'(rd_fill_reg)};
        end
    end

    assign res = read_phase_reg ? rd_res_reg : res_reg;
endmodule

[hdl/breakpoint_watchpoint_matcher.sv]
// Breakpoint and watchpoint comparator for a CPU debug port.
// done rises in the cycle after start is taken; for a log read it follows S_READ.
// Throughput: one item per cycle when not busy; a log read holds busy for
//   one cycle while the hit log RAM (one registered read port) gives its entry.
// Reset (async, active low) empties the table and log and clears pending;
//   the receiver cannot stall, each result is flagged by done for exactly one cycle.
module breakpoint_watchpoint_matcher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bwm_pkg::in_item_t  item,
    output logic               done,
    output bwm_pkg::out_item_t result
);
    import bwm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bwm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bwm_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .item  (item),
        .sts   (sts),
        .done  (done),
        .res   (result)
    );

    // hold busy for exactly one cycle after a log read is taken
    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy) else $error("busy held too long");
    // a strobe follows every accepted item that needs no log read
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !sts.need_read) |=> done) else $error("lost result");
    // a hit result never reports an error status
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.status == ST_OK)) else $error("bad hit");
endmodule
